@@ design/kst_pkg.sv @@
`timescale 1ns / 1ps

package kst_pkg;

    // input item kinds
    localparam logic [1:0] KIND_SCAN  = 2'd0;
    localparam logic [1:0] KIND_POLL  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // result types
    localparam logic [1:0] RES_CHAR = 2'd0;
    localparam logic [1:0] RES_BKSP = 2'd1;
    localparam logic [1:0] RES_KBD  = 2'd2;

    // keyboard bytes
    localparam logic [7:0] LED_CMD       = 8'hED;
    localparam logic [7:0] SC_LSHIFT_MK  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MK  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [7:0] SC_CAPS       = 8'h3A;
    localparam logic [7:0] SC_NUM        = 8'h45;
    localparam logic [7:0] SC_SCROLL     = 8'h46;
    localparam logic [7:0] SC_ACK        = 8'hFA;
    localparam logic [7:0] SC_RESEND     = 8'hFE;
    localparam logic [7:0] SC_BKSP       = 8'h0E;

    // lock LED bits
    localparam logic [2:0] LED_SCROLL = 3'b001;
    localparam logic [2:0] LED_NUM    = 3'b010;
    localparam logic [2:0] LED_CAPS   = 3'b100;

    localparam logic [7:0] ASCII_A    = 8'h41;
    localparam logic [7:0] ASCII_Z    = 8'h5A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // one result word
    typedef struct packed {
        logic [1:0] result_type;
        logic [7:0] value;
        logic       queue_dropped;
        logic       last;
    } result_t;

    // one queued LED command: 0xED then the LED byte, unless the LED byte was dropped
    typedef struct packed {
        logic [2:0] leds;
        logic       full;
    } pair_t;

    localparam int PAIR_W = $bits(pair_t);

    // unshifted Japanese layout
    function automatic logic [7:0] plain_map(input logic [6:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                7'h02: c = "1";
                7'h03: c = "2";
                7'h04: c = "3";
                7'h05: c = "4";
                7'h06: c = "5";
                7'h07: c = "6";
                7'h08: c = "7";
                7'h09: c = "8";
                7'h0A: c = "9";
                7'h0B: c = "0";
                7'h0C: c = "-";
                7'h0D: c = "^";
                7'h10: c = "Q";
                7'h11: c = "W";
                7'h12: c = "E";
                7'h13: c = "R";
                7'h14: c = "T";
                7'h15: c = "Y";
                7'h16: c = "U";
                7'h17: c = "I";
                7'h18: c = "O";
                7'h19: c = "P";
                7'h1A: c = "@";
                7'h1B: c = "[";
                7'h1E: c = "A";
                7'h1F: c = "S";
                7'h20: c = "D";
                7'h21: c = "F";
                7'h22: c = "G";
                7'h23: c = "H";
                7'h24: c = "J";
                7'h25: c = "K";
                7'h26: c = "L";
                7'h27: c = ";";
                7'h28: c = ":";
                7'h2B: c = "]";
                7'h2C: c = "Z";
                7'h2D: c = "X";
                7'h2E: c = "C";
                7'h2F: c = "V";
                7'h30: c = "B";
                7'h31: c = "N";
                7'h32: c = "M";
                7'h33: c = ",";
                7'h34: c = ".";
                7'h35: c = "/";
                7'h37: c = "*";
                7'h39: c = " ";
                7'h47: c = "7";
                7'h48: c = "8";
                7'h49: c = "9";
                7'h4A: c = "-";
                7'h4B: c = "4";
                7'h4C: c = "5";
                7'h4D: c = "6";
                7'h4E: c = "+";
                7'h4F: c = "1";
                7'h50: c = "2";
                7'h51: c = "3";
                7'h52: c = "0";
                7'h53: c = ".";
                7'h73: c = 8'h5C;
                7'h7D: c = 8'h5C;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // shifted layout: only the differing keys, the rest as unshifted
    function automatic logic [7:0] shifted_map(input logic [6:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                7'h02: c = "!";
                7'h03: c = 8'h22;
                7'h04: c = "#";
                7'h05: c = "$";
                7'h06: c = "%";
                7'h07: c = "&";
                7'h08: c = 8'h27;
                7'h09: c = "(";
                7'h0A: c = ")";
                7'h0B: c = "~";
                7'h0C: c = "=";
                7'h0D: c = "~";
                7'h1A: c = 8'h60;
                7'h1B: c = "{";
                7'h27: c = "+";
                7'h28: c = "*";
                7'h2B: c = "}";
                7'h33: c = "<";
                7'h34: c = ">";
                7'h35: c = "?";
                7'h73: c = "_";
                7'h7D: c = "|";
                default: c = plain_map(idx);
            endcase
            return c;
        end
    endfunction

endpackage

@@ design/kst_if.sv @@
`timescale 1ns / 1ps

// input word channel
interface kst_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] scancode;

    modport source (output valid, output kind, output scancode, input ready);
    modport sink (input valid, input kind, input scancode, output ready);
endinterface

// result word channel
interface kst_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] result_type;
    logic [7:0] value;
    logic       queue_dropped;
    logic       last;

    modport source (output valid, output result_type, output value,
                    output queue_dropped, output last, input ready);
    modport sink (input valid, input result_type, input value,
                  input queue_dropped, input last, output ready);
endinterface

// configuration write channel
interface kst_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] initial_leds;

    modport source (output valid, output initial_leds, input ready);
    modport sink (input valid, input initial_leds, output ready);
endinterface

@@ design/kst_ram.sv @@
`timescale 1ns / 1ps

module kst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/kst_keymap.sv @@
`timescale 1ns / 1ps

module kst_keymap
    import kst_pkg::*;
(
    input  logic [7:0] scancode,
    input  logic       shifted,
    input  logic       caps,
    output logic       char_valid,
    output logic [7:0] char_code,
    output logic       bksp
);

    logic [7:0] raw;

    // table lookup for make codes, then case fix for letters
    always_comb
    begin
        if (scancode[7])
        begin
            raw = 8'h00;
        end
        else if (shifted)
        begin
            raw = shifted_map(scancode[6:0]);
        end
        else
        begin
            raw = plain_map(scancode[6:0]);
        end

        if (raw >= ASCII_A && raw <= ASCII_Z && caps == shifted)
        begin
            char_code = raw + CASE_DELTA;
        end
        else
        begin
            char_code = raw;
        end
    end

    assign char_valid = (raw != 8'h00);
    assign bksp       = (scancode == SC_BKSP);

endmodule

@@ design/kst_out_buf.sv @@
`timescale 1ns / 1ps

module kst_out_buf
    import kst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic       res0_valid,
    input  result_t    res0,
    input  logic       res1_valid,
    input  result_t    res1,
    output logic       can_load,
    kst_out_if.source  result
);

    logic    a_valid_reg, a_valid_next;
    logic    b_valid_reg, b_valid_next;
    result_t a_reg, a_next;
    result_t b_reg, b_next;
    logic    take;

    assign take     = a_valid_reg && result.ready;
    // room for two words once the front word leaves
    assign can_load = !b_valid_reg && (!a_valid_reg || result.ready);

    // shift the second word forward, or load a new pair
    always_comb
    begin
        a_valid_next = a_valid_reg;
        b_valid_next = b_valid_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        if (take)
        begin
            a_valid_next = b_valid_reg;
            a_next       = b_reg;
            b_valid_next = 1'b0;
        end
        if (load)
        begin
            a_valid_next = res0_valid;
            a_next       = res0;
            b_valid_next = res1_valid;
            b_next       = res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign result.valid         = a_valid_reg;
    assign result.result_type   = a_reg.result_type;
    assign result.value         = a_reg.value;
    assign result.queue_dropped = a_reg.queue_dropped;
    assign result.last          = a_reg.last;

endmodule

@@ design/keyboard_scancode_translator.sv @@
`timescale 1ns / 1ps

// PS/2 set-1 scancode translator. Each accepted word (scancode, idle poll or
// start) is registered, processed once the output buffer can take it and gives
// up to two result words: a character, backspace or resend, then possibly the
// next queued keyboard byte. A word that gives at most one result can follow
// every cycle while the result channel is ready; one that gives two fills the
// two-word output buffer, as the result channel moves one word per cycle.
// Lock keys and start queue 0xED plus the LED byte in a command queue of
// CMD_QUEUE_DEPTH bytes, held in a RAM as one entry per LED command; a byte
// that does not fit is dropped and flagged on that word's results. The next
// queued byte goes out only after 0xFA from the keyboard. No clearing pass is
// needed after reset. initial_leds is loaded on start.

module keyboard_scancode_translator
    import kst_pkg::*;
#(
    parameter int CMD_QUEUE_DEPTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    kst_in_if.sink    item,
    kst_out_if.source result,
    kst_cfg_if.sink   cfg
);

    localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
    localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(CMD_QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ROOM2_C  = CNT_W'(CMD_QUEUE_DEPTH - 2);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_QUEUE_DEPTH - 1);

    // input register
    logic       in_valid_reg;
    logic [1:0] in_kind_reg;
    logic [7:0] in_sc_reg;

    // translator state
    logic [2:0] init_leds_reg;
    logic [1:0] shift_reg, shift_next;
    logic [2:0] leds_reg, leds_next;
    logic       awaiting_reg, awaiting_next;
    logic [7:0] flight_reg, flight_next;

    // command queue control
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] bytes_reg, bytes_next;
    logic [CNT_W-1:0] pairs_reg, pairs_next;
    logic             phase_reg, phase_next;
    pair_t            head_reg, head_next;
    logic             head_in_ram_reg, head_in_ram_next;

    logic [PAIR_W-1:0] ram_rdata;
    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    pair_t             ram_wdata;

    logic       fire;
    logic       can_load;
    logic       char_valid;
    logic [7:0] char_code;
    logic       bksp;

    logic             push_req;
    logic             pushed;
    logic             dropped;
    logic [CNT_W-1:0] bytes_pre;
    pair_t            head_cur;
    logic             item_res_valid;
    result_t          item_res;
    logic             send_valid;
    result_t          send_res;
    logic             res0_valid;
    result_t          res0;
    logic             res1_valid;
    result_t          res1;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    assign fire       = in_valid_reg && can_load;
    assign item.ready = !in_valid_reg || fire;
    assign cfg.ready  = 1'b1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_kind_reg <= item.kind;
            in_sc_reg   <= item.scancode;
        end
    end

    kst_keymap u_keymap (
        .scancode   (in_sc_reg),
        .shifted    (shift_reg != 2'b00),
        .caps       ((leds_reg & LED_CAPS) != 3'b000),
        .char_valid (char_valid),
        .char_code  (char_code),
        .bksp       (bksp)
    );

    kst_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_ptr_next),
        .rdata (ram_rdata)
    );

    assign head_cur = head_in_ram_reg ? pair_t'(ram_rdata) : head_reg;

    // one step: item result, LED command push, then send attempt
    always_comb
    begin
        shift_next       = shift_reg;
        leds_next        = leds_reg;
        awaiting_next    = awaiting_reg;
        flight_next      = flight_reg;
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        bytes_next       = bytes_reg;
        pairs_next       = pairs_reg;
        phase_next       = phase_reg;
        head_next        = head_cur;
        head_in_ram_next = 1'b0;
        push_req         = 1'b0;
        pushed           = 1'b0;
        dropped          = 1'b0;
        bytes_pre        = bytes_reg;
        ram_we           = 1'b0;
        ram_waddr        = wr_ptr_reg;
        ram_wdata        = '{leds: leds_reg, full: 1'b1};
        item_res_valid   = 1'b0;
        item_res         = '{result_type: RES_CHAR, value: char_code,
                             queue_dropped: 1'b0, last: 1'b1};
        send_valid       = 1'b0;
        send_res         = '{result_type: RES_KBD, value: LED_CMD,
                             queue_dropped: 1'b0, last: 1'b1};

        if (fire)
        begin
            unique case (in_kind_reg)
                KIND_START:
                begin
                    shift_next    = 2'b00;
                    leds_next     = init_leds_reg;
                    awaiting_next = 1'b0;
                    rd_ptr_next   = '0;
                    wr_ptr_next   = '0;
                    bytes_next    = '0;
                    pairs_next    = '0;
                    phase_next    = 1'b0;
                    push_req      = 1'b1;
                end
                KIND_SCAN:
                begin
                    // the item's own result
                    if (char_valid)
                    begin
                        item_res_valid = 1'b1;
                    end
                    else if (bksp)
                    begin
                        item_res_valid       = 1'b1;
                        item_res.result_type = RES_BKSP;
                        item_res.value       = 8'h00;
                    end
                    else if (in_sc_reg == SC_RESEND && awaiting_reg)
                    begin
                        item_res_valid       = 1'b1;
                        item_res.result_type = RES_KBD;
                        item_res.value       = flight_reg;
                    end

                    // modifier, lock and ack bytes
                    unique case (in_sc_reg)
                        SC_LSHIFT_MK:  shift_next = shift_reg | 2'b01;
                        SC_RSHIFT_MK:  shift_next = shift_reg | 2'b10;
                        SC_LSHIFT_BRK: shift_next = shift_reg & 2'b10;
                        SC_RSHIFT_BRK: shift_next = shift_reg & 2'b01;
                        SC_CAPS:
                        begin
                            leds_next = leds_reg ^ LED_CAPS;
                            push_req  = 1'b1;
                        end
                        SC_NUM:
                        begin
                            leds_next = leds_reg ^ LED_NUM;
                            push_req  = 1'b1;
                        end
                        SC_SCROLL:
                        begin
                            leds_next = leds_reg ^ LED_SCROLL;
                            push_req  = 1'b1;
                        end
                        SC_ACK:        awaiting_next = 1'b0;
                        default:       ;
                    endcase
                end
                default: ;
            endcase

            // queue 0xED plus LED byte; one RAM entry per command
            bytes_pre = bytes_next;
            if (push_req)
            begin
                dropped = (bytes_pre > ROOM2_C);
                if (bytes_pre < DEPTH_C)
                begin
                    pushed         = 1'b1;
                    ram_we         = 1'b1;
                    ram_waddr      = wr_ptr_next;
                    ram_wdata.leds = leds_next;
                    ram_wdata.full = (bytes_pre <= ROOM2_C);
                    if (pairs_next == '0)
                    begin
                        head_next = ram_wdata;
                    end
                    wr_ptr_next = ptr_inc(wr_ptr_next);
                    pairs_next  = pairs_next + 1'b1;
                    bytes_next  = bytes_pre + (ram_wdata.full ? CNT_W'(2) : CNT_W'(1));
                end
            end

            // send any head byte when no ack is pending and kind is not NONE
            if (in_kind_reg != KIND_NONE && bytes_next != '0 && !awaiting_next)
            begin
                send_valid     = 1'b1;
                send_res.value = phase_next ? {5'b00000, head_next.leds} : LED_CMD;
                awaiting_next  = 1'b1;
                flight_next    = send_res.value;
                bytes_next     = bytes_next - 1'b1;
                if (!phase_next && head_next.full)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    phase_next  = 1'b0;
                    rd_ptr_next = ptr_inc(rd_ptr_next);
                    pairs_next  = pairs_next - 1'b1;
                    if (pushed && pairs_next == CNT_W'(1))
                    begin
                        head_next = ram_wdata;
                    end
                    else if (pairs_next != '0)
                    begin
                        head_in_ram_next = 1'b1;
                    end
                end
            end
        end

        item_res.queue_dropped = dropped;
        send_res.queue_dropped = dropped;
    end

    // pack the words in order for the output buffer
    always_comb
    begin
        res0       = item_res_valid ? item_res : send_res;
        res0.last  = !(item_res_valid && send_valid);
        res0_valid = item_res_valid || send_valid;
        res1       = send_res;
        res1_valid = item_res_valid && send_valid;
    end

    kst_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .res0_valid (res0_valid),
        .res0       (res0),
        .res1_valid (res1_valid),
        .res1       (res1),
        .can_load   (can_load),
        .result     (result)
    );

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_leds_reg   <= 3'b000;
            shift_reg       <= 2'b00;
            leds_reg        <= 3'b000;
            awaiting_reg    <= 1'b0;
            flight_reg      <= 8'h00;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            bytes_reg       <= '0;
            pairs_reg       <= '0;
            phase_reg       <= 1'b0;
            head_in_ram_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                init_leds_reg <= cfg.initial_leds;
            end
            shift_reg       <= shift_next;
            leds_reg        <= leds_next;
            awaiting_reg    <= awaiting_next;
            flight_reg      <= flight_next;
            rd_ptr_reg      <= rd_ptr_next;
            wr_ptr_reg      <= wr_ptr_next;
            bytes_reg       <= bytes_next;
            pairs_reg       <= pairs_next;
            phase_reg       <= phase_next;
            head_in_ram_reg <= head_in_ram_next;
        end
    end

    // cached queue head
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
    end

endmodule

@@ design/kst_checker.sv @@
`timescale 1ns / 1ps

module kst_checker
    import kst_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] res_type,
    input logic [7:0] res_value,
    input logic       res_dropped,
    input logic       res_last
);

    // a word sent to the keyboard always closes its item
    a_kbd_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_type == RES_KBD |-> res_last)
        else $error("keyboard word not marked last");

    // a non-last word is followed straight away by the keyboard word
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=> res_valid && res_type == RES_KBD)
        else $error("second word of an item missing");

    // drop flag is the same on both words of an item
    a_drop_same: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=> res_dropped == $past(res_dropped))
        else $error("drop flag differs within an item");

    // backspace carries a zero value
    a_bksp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_type == RES_BKSP |-> res_value == 8'h00)
        else $error("backspace with non-zero value");

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid
            && $stable({res_type, res_value, res_dropped, res_last}))
        else $error("result word changed while stalled");

endmodule

bind keyboard_scancode_translator kst_checker u_kst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .res_type    (result.result_type),
    .res_value   (result.value),
    .res_dropped (result.queue_dropped),
    .res_last    (result.last)
);
